/* design/counting_semaphore_wait_queue_assert.svh */
// Assertion macros for the counting semaphore block.
// Used by the checker module; depends on a clock named i_clk and a reset named i_rst_n.
`ifndef COUNTING_SEMAPHORE_WAIT_QUEUE_ASSERT_SVH
`define COUNTING_SEMAPHORE_WAIT_QUEUE_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define CSEM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("semaphore check failed: next-cycle rule");

// The consequent must hold in the same cycle as the antecedent.
`define CSEM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("semaphore check failed: same-cycle rule");

`endif

/* design/csem_pkg.sv */
// Shared types and constants for the counting semaphore block.
// No dependencies.
package csem_pkg;

    // Widths of the fixed item fields.
    localparam int unsigned TASK_W    = 8;
    localparam int unsigned COUNT_W   = 8;
    localparam int unsigned WAITERS_W = 5;

    // Reset value of the holder limit: one holder, i.e. a mutex.
    localparam logic [COUNT_W-1:0] LIMIT_RESET = 8'd1;

    // Request kinds.
    typedef enum logic {
        ACT_ACQUIRE = 1'b0,
        ACT_RELEASE = 1'b1
    } t_action;

    // Result codes.
    typedef enum logic [2:0] {
        OUT_GRANTED    = 3'd0,
        OUT_QUEUED     = 3'd1,
        OUT_LOWERED    = 3'd2,
        OUT_HANDED     = 3'd3,
        OUT_IGNORED    = 3'd4,
        OUT_QUEUE_FULL = 3'd5
    } t_outcome;

    // Result control passed from the controller to the top level.
    typedef struct packed {
        logic valid;
        logic hand_over;
    } t_res_ctl;

endpackage

/* design/csem_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module csem_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/csem_ctrl.sv */
// Controller of the counting semaphore: holder count, queue pointers, limit and results.
// Depends on csem_pkg; drives the waiter RAM ports of the top level.
module csem_ctrl
    import csem_pkg::*;
#(
    parameter int unsigned WAIT_DEPTH = 16,
    parameter int unsigned PTR_W      = 4,
    parameter int unsigned TID_W      = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic                 i_action,
    input  logic [TID_W-1:0]     i_task,
    input  logic                 i_cfg_we,
    input  logic [COUNT_W-1:0]   i_cfg_wdata,
    output logic                 o_ram_we,
    output logic [PTR_W-1:0]     o_ram_waddr,
    output logic [TID_W-1:0]     o_ram_wdata,
    output logic                 o_ram_re,
    output logic [PTR_W-1:0]     o_ram_raddr,
    output t_res_ctl             o_res_ctl,
    output logic [2:0]           o_outcome,
    output logic [COUNT_W-1:0]   o_holders,
    output logic [WAITERS_W-1:0] o_waiters
);

    localparam int unsigned OCC_W = $clog2(WAIT_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(WAIT_DEPTH - 1);
    localparam logic [OCC_W-1:0] FULL_OCC  = OCC_W'(WAIT_DEPTH);

    logic [COUNT_W-1:0] r_limit;
    logic [COUNT_W-1:0] r_held,  n_held;
    logic [PTR_W-1:0]   r_head,  n_head;
    logic [PTR_W-1:0]   r_tail,  n_tail;
    logic [OCC_W-1:0]   r_occ,   n_occ;
    t_outcome           r_outcome, n_outcome;
    t_res_ctl           r_res,   n_res;
    logic               push, pop;

    // Decide the request from the current count and queue fill.
    always_comb begin
        n_held    = r_held;
        n_head    = r_head;
        n_tail    = r_tail;
        n_occ     = r_occ;
        n_outcome = OUT_IGNORED;
        push      = 1'b0;
        pop       = 1'b0;
        if (i_action == ACT_ACQUIRE) begin
            if (r_held < r_limit) begin
                n_held    = r_held + 1'b1;
                n_outcome = OUT_GRANTED;
            end else if (r_occ == FULL_OCC) begin
                n_outcome = OUT_QUEUE_FULL;
            end else begin
                push      = 1'b1;
                n_tail    = (r_tail == LAST_SLOT) ? '0 : r_tail + 1'b1;
                n_occ     = r_occ + 1'b1;
                n_outcome = OUT_QUEUED;
            end
        end else begin
            if (r_occ != '0) begin
                pop       = 1'b1;
                n_head    = (r_head == LAST_SLOT) ? '0 : r_head + 1'b1;
                n_occ     = r_occ - 1'b1;
                n_outcome = OUT_HANDED;
            end else if (r_held != '0) begin
                n_held    = r_held - 1'b1;
                n_outcome = OUT_LOWERED;
            end else begin
                n_outcome = OUT_IGNORED;
            end
        end
        n_res.valid     = i_accept;
        n_res.hand_over = i_accept & pop;
    end

    // Waiter RAM: push at the tail, pop reads the head; data arrives with the result.
    assign o_ram_we    = i_accept & push;
    assign o_ram_waddr = r_tail;
    assign o_ram_wdata = i_task;
    assign o_ram_re    = i_accept & pop;
    assign o_ram_raddr = r_head;

    // Control state and the limit register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
            r_held  <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_occ   <= '0;
            r_res   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (i_accept) begin
                r_held <= n_held;
                r_head <= n_head;
                r_tail <= n_tail;
                r_occ  <= n_occ;
            end
            r_res <= n_res;
        end
    end

    // Result payload, captured with each accepted item.
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_outcome <= n_outcome;
        end
    end

    assign o_res_ctl = r_res;
    assign o_outcome = r_outcome;
    assign o_holders = r_held;
    assign o_waiters = WAITERS_W'(r_occ);

endmodule

/* design/counting_semaphore_wait_queue.sv */
// Top level of the counting semaphore with a FIFO wait queue.
// Depends on csem_pkg, csem_ctrl and csem_ram.
//
//  Channel   Handshake              Fields
//  request   start / busy           i_action, i_task_id
//  result    o_done (one cycle)     o_outcome, o_wake_task, o_holders, o_waiters
//  config    i_cfg_we               i_cfg_wdata (holder limit)
//
// A request is taken on any edge with start high and busy low; its result
// shows on the following cycle for that cycle only. One request can be taken
// every cycle while busy is low: a request makes at most one access, a push
// write or a pop read of the waiter RAM, and the popped entry comes out of its
// read register alongside the result. Busy is high in the first cycle after reset
// and low from then on. The reset is synchronous and active low; the waiter
// RAM is not cleared.
module counting_semaphore_wait_queue
    import csem_pkg::*;
#(
    parameter int unsigned WAIT_DEPTH   = 16,
    parameter int unsigned TASK_ID_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_action,
    input  logic [TASK_W-1:0]    i_task_id,
    input  logic                 i_cfg_we,
    input  logic [COUNT_W-1:0]   i_cfg_wdata,
    output logic                 o_done,
    output logic [2:0]           o_outcome,
    output logic [TASK_W-1:0]    o_wake_task,
    output logic [COUNT_W-1:0]   o_holders,
    output logic [WAITERS_W-1:0] o_waiters
);

    localparam int unsigned PTR_W = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int unsigned TID_W = (TASK_ID_BITS < TASK_W) ? TASK_ID_BITS : TASK_W;

    logic              r_busy;
    logic              accept;
    logic              ram_we, ram_re;
    logic [PTR_W-1:0]  ram_waddr, ram_raddr;
    logic [TID_W-1:0]  ram_wdata, ram_rdata;
    t_res_ctl          res_ctl;

    // Hold off requests for the first cycle out of reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy   = r_busy;
    assign accept = start & ~r_busy;

    csem_ctrl #(
        .WAIT_DEPTH (WAIT_DEPTH),
        .PTR_W      (PTR_W),
        .TID_W      (TID_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_action    (i_action),
        .i_task      (i_task_id[TID_W-1:0]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .o_res_ctl   (res_ctl),
        .o_outcome   (o_outcome),
        .o_holders   (o_holders),
        .o_waiters   (o_waiters)
    );

    csem_ram #(
        .WIDTH (TID_W),
        .DEPTH (WAIT_DEPTH)
    ) u_wait_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // The woken task is shown only on a hand-over, otherwise zero.
    assign o_done      = res_ctl.valid;
    assign o_wake_task = res_ctl.hand_over ? TASK_W'(ram_rdata) : '0;

endmodule

/* design/csem_checker.sv */
// Port-level checker for the counting semaphore, bound to the top level.
// Depends on csem_pkg and counting_semaphore_wait_queue_assert.svh.
`include "counting_semaphore_wait_queue_assert.svh"

module csem_checker
    import csem_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 o_done,
    input logic [2:0]           o_outcome,
    input logic [TASK_W-1:0]    o_wake_task,
    input logic [COUNT_W-1:0]   o_holders,
    input logic [WAITERS_W-1:0] o_waiters
);

    // Every accepted item gives exactly one result on the next cycle.
    `CSEM_ASSERT_NEXT(a_result_follows, start && !busy, o_done)
    `CSEM_ASSERT_NEXT(a_no_spurious, !(start && !busy), !o_done)

    // A woken task is reported only on a hand-over.
    `CSEM_ASSERT_NOW(a_wake_zero, o_done && o_outcome != OUT_HANDED, o_wake_task == '0)

    // A grant leaves at least one holder; a queued item leaves a waiter.
    `CSEM_ASSERT_NOW(a_grant_held, o_done && o_outcome == OUT_GRANTED, o_holders != '0)
    `CSEM_ASSERT_NOW(a_queued_waits, o_done && o_outcome == OUT_QUEUED, o_waiters != '0)

endmodule

bind counting_semaphore_wait_queue csem_checker u_csem_checker (.*);

/* tb/sv/counting_semaphore_wait_queue_tb.sv */
// Self-checking testbench for the counting semaphore with a FIFO wait queue.
// Depends on csem_pkg and the counting_semaphore_wait_queue top level; it predicts
// every result from its own model of the holder count and the waiter FIFO.
module counting_semaphore_wait_queue_tb;
    import csem_pkg::*;

    localparam int unsigned WAIT_DEPTH = 16;
    localparam int unsigned MAX_SHOWN  = 10;

    // One predicted result of a request.
    typedef struct {
        t_outcome              outcome;
        logic [TASK_W-1:0]     wake_task;
        logic [COUNT_W-1:0]    holders;
        logic [WAITERS_W-1:0]  waiters;
    } t_sem_reply;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic                  i_action;
    logic [TASK_W-1:0]     i_task_id;
    logic                  i_cfg_we;
    logic [COUNT_W-1:0]    i_cfg_wdata;
    logic                  o_done;
    logic [2:0]            o_outcome;
    logic [TASK_W-1:0]     o_wake_task;
    logic [COUNT_W-1:0]    o_holders;
    logic [WAITERS_W-1:0]  o_waiters;

    // Model state: configured limit, held count and the queue of waiting tasks.
    logic [COUNT_W-1:0]    limit_model;
    logic [COUNT_W-1:0]    held_model;
    logic [TASK_W-1:0]     waiter_model[$];

    // Results still to come from the block, oldest first.
    t_sem_reply            replies_due[$];

    int unsigned           fail_count     = 0;
    int unsigned           requests_sent  = 0;
    int unsigned           limits_written = 0;
    int unsigned           burst_left     = 0;
    int unsigned           outcome_seen[6];

    counting_semaphore_wait_queue #(
        .WAIT_DEPTH   (WAIT_DEPTH),
        .TASK_ID_BITS (8)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_action    (i_action),
        .i_task_id   (i_task_id),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_done      (o_done),
        .o_outcome   (o_outcome),
        .o_wake_task (o_wake_task),
        .o_holders   (o_holders),
        .o_waiters   (o_waiters)
    );

    // Free-running clock with a period of two units.
    always #1 i_clk = ~i_clk;

    // Counts a failure and reports only the first few in full.
    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_SHOWN) begin
            $display("mismatch %0d: %s", fail_count, msg);
        end
    endfunction

    // Works out the result of one request and advances the semaphore model.
    function automatic t_sem_reply predict_semaphore(input t_action act,
                                                     input logic [TASK_W-1:0] tid);
        t_sem_reply r;
        r.wake_task = '0;
        if (act == ACT_ACQUIRE) begin
            if (held_model < limit_model) begin
                held_model = held_model + 1'b1;
                r.outcome  = OUT_GRANTED;
            end else if (waiter_model.size() >= WAIT_DEPTH) begin
                r.outcome = OUT_QUEUE_FULL;
            end else begin
                waiter_model.push_back(tid);
                r.outcome = OUT_QUEUED;
            end
        end else if (waiter_model.size() > 0) begin
            // The slot passes straight to the oldest waiter.
            r.wake_task = waiter_model.pop_front();
            r.outcome   = OUT_HANDED;
        end else if (held_model > 0) begin
            held_model = held_model - 1'b1;
            r.outcome  = OUT_LOWERED;
        end else begin
            r.outcome = OUT_IGNORED;
        end
        r.holders = held_model;
        r.waiters = WAITERS_W'(waiter_model.size());
        return r;
    endfunction

    // Compares one result from the block with the oldest prediction.
    task automatic check_reply();
        t_sem_reply exp_r;
        if (replies_due.size() == 0) begin
            note_failure($sformatf("result with none pending: outcome %0d wake %0d",
                                   o_outcome, o_wake_task));
        end else begin
            exp_r = replies_due.pop_front();
            outcome_seen[exp_r.outcome]++;
            if (o_outcome !== exp_r.outcome || o_wake_task !== exp_r.wake_task ||
                o_holders !== exp_r.holders || o_waiters !== exp_r.waiters) begin
                note_failure($sformatf(
                    "expected outcome %0d wake %0d holders %0d waiters %0d, got %0d %0d %0d %0d",
                    exp_r.outcome, exp_r.wake_task, exp_r.holders, exp_r.waiters,
                    o_outcome, o_wake_task, o_holders, o_waiters));
            end
        end
    endtask

    // Every result is taken at the edge that ends its cycle.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if ($isunknown(o_done)) begin
                note_failure("done strobe is unknown");
            end else if (o_done) begin
                check_reply();
            end
        end
    end

    // Presents one item and returns at the edge that accepts it.
    task automatic send_request(input t_action act, input logic [TASK_W-1:0] tid);
        start     <= 1'b1;
        i_action  <= act;
        i_task_id <= tid;
        do @(posedge i_clk); while (busy !== 1'b0);
        replies_due.push_back(predict_semaphore(act, tid));
        requests_sent++;
    endtask

    // Inserts a random gap between bursts of back-to-back items.
    task automatic pace_sender();
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
    endtask

    // Stops sending and waits until every pending result has come back.
    task automatic drain_results();
        start <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // Writes the holder limit while the block is idle.
    task automatic write_limit(input logic [COUNT_W-1:0] value);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        limit_model = value;
        limits_written++;
        i_cfg_we    <= 1'b0;
    endtask

    // Reset limit of one: grant, queue, hand over, lower and an ignored release.
    task automatic test_mutex_basics();
        send_request(ACT_ACQUIRE, 8'h00);
        send_request(ACT_ACQUIRE, 8'hFF);
        send_request(ACT_RELEASE, 8'h00);
        send_request(ACT_RELEASE, 8'hFF);
        send_request(ACT_RELEASE, 8'h5A);
    endtask

    // A limit dropped to zero beneath a held slot: acquires queue, release hands over.
    task automatic test_limit_below_count();
        write_limit(8'd255);
        send_request(ACT_ACQUIRE, 8'h12);
        write_limit(8'd0);
        send_request(ACT_ACQUIRE, 8'hAA);
        send_request(ACT_RELEASE, 8'h55);
    endtask

    // Fills the wait queue to the brim and then tries one more acquire.
    task automatic test_queue_overflow();
        repeat (WAIT_DEPTH + 1) begin
            send_request(ACT_ACQUIRE, TASK_W'($urandom_range(0, 255)));
        end
    endtask

    // Random requests at one limit, acquires taken with the given bias in percent.
    task automatic test_random_traffic(input logic [COUNT_W-1:0] limit,
                                       input int unsigned n_items,
                                       input int unsigned acquire_pct);
        t_action act;
        write_limit(limit);
        repeat (n_items) begin
            pace_sender();
            act = ($urandom_range(0, 99) < acquire_pct) ? ACT_ACQUIRE : ACT_RELEASE;
            send_request(act, TASK_W'($urandom_range(0, 255)));
        end
    endtask

    // Main sequence: reset, directed cases, then random traffic at several limits.
    initial begin
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_action    <= ACT_ACQUIRE;
        i_task_id   <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        limit_model = LIMIT_RESET;
        held_model  = '0;
        foreach (outcome_seen[k]) outcome_seen[k] = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_mutex_basics();
        test_limit_below_count();
        test_queue_overflow();

        test_random_traffic(8'd1,   60, 55);
        test_random_traffic(8'd0,   40, 50);
        test_random_traffic(8'd255, 100, 85);
        // Follows a high count, so the limit starts well below it.
        test_random_traffic(8'd4,   70, 45);
        test_random_traffic(COUNT_W'($urandom_range(0, 255)), 60, 60);
        test_random_traffic(COUNT_W'($urandom_range(1, 8)),   70, 50);

        drain_results();
        repeat (4) @(posedge i_clk);
        if (replies_due.size() != 0) begin
            note_failure($sformatf("%0d results never arrived", replies_due.size()));
        end

        $display("Covered %0d requests under %0d holder limits, results by outcome:",
                 requests_sent, limits_written);
        $display("granted %0d, queued %0d, lowered %0d, handed %0d, ignored %0d, full %0d",
                 outcome_seen[OUT_GRANTED], outcome_seen[OUT_QUEUED],
                 outcome_seen[OUT_LOWERED], outcome_seen[OUT_HANDED],
                 outcome_seen[OUT_IGNORED], outcome_seen[OUT_QUEUE_FULL]);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog: stops a run that never finishes.
    initial begin
        #200000;
        $display("Run timed out with %0d results pending.", replies_due.size());
        $display("status: fail");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+design
design/csem_pkg.sv
design/csem_ram.sv
design/csem_ctrl.sv
design/counting_semaphore_wait_queue.sv
design/csem_checker.sv
tb/sv/counting_semaphore_wait_queue_tb.sv
